// File: src/gle_pkg.sv
// ----------------------------------------------------------------------------
// gle_pkg
// Shared types, codes and saturation helpers for the glyph layout engine.
// ----------------------------------------------------------------------------
`default_nettype none

package gle_pkg;

  // input opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_BEGIN = 2'd1;
  localparam logic [1:0] OP_CHAR  = 2'd2;

  // special character codes
  localparam logic [15:0] CODE_NEWLINE = 16'd10;
  localparam logic [15:0] CODE_SPACE   = 16'd32;

  // saturation limits
  localparam logic signed [26:0] POS_MAX = 27'sd524287;
  localparam logic signed [26:0] POS_MIN = -27'sd524288;
  localparam logic [20:0]        SIZE_MAX = 21'd1048575;

  // one glyph table entry
  typedef struct packed {
    logic [3:0]         page;
    logic [11:0]        tex_x;
    logic [11:0]        tex_y;
    logic [11:0]        tex_w;
    logic [11:0]        tex_h;
    logic signed [11:0] x_off;
    logic signed [11:0] y_off;
    logic signed [11:0] x_adv;
  } glyph_t;

  // what the back end has to do with a word
  typedef enum logic [1:0] {
    KIND_BEGIN   = 2'd0,
    KIND_NEWLINE = 2'd1,
    KIND_MISS    = 2'd2,
    KIND_GLYPH   = 2'd3
  } kind_t;

  // classified job passed from front to back through the queue
  typedef struct packed {
    kind_t              kind;
    logic signed [19:0] org_x;
    logic signed [19:0] org_y;
    logic [3:0]         page;
    logic [11:0]        src_x;
    logic [11:0]        src_y;
    logic [11:0]        src_w;
    logic [11:0]        src_h;
    logic signed [11:0] x_off;
    logic signed [11:0] y_off;
    logic signed [21:0] step;
    logic [19:0]        dst_w;
    logic [19:0]        dst_h;
  } job_t;

  // configuration registers
  typedef struct packed {
    logic [11:0]        line_height;
    logic [11:0]        scale_q8;
    logic signed [15:0] rot_cos;
    logic signed [15:0] rot_sin;
    logic [7:0]         missing_advance;
  } cfg_t;

  // clamp to signed 20 bit position
  function automatic logic signed [19:0] sat_pos(input logic signed [26:0] v);
    logic signed [19:0] r;
    if (v > POS_MAX) begin
      r = 20'sh7FFFF;
    end else if (v < POS_MIN) begin
      r = 20'sh80000;
    end else begin
      r = v[19:0];
    end
    return r;
  endfunction

  // clamp to unsigned 20 bit size
  function automatic logic [19:0] sat_size(input logic [20:0] v);
    logic [19:0] r;
    if (v > SIZE_MAX) begin
      r = 20'hFFFFF;
    end else begin
      r = v[19:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/gle_ram.sv
// ----------------------------------------------------------------------------
// gle_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/gle_front.sv
// ----------------------------------------------------------------------------
// gle_front
// Accepts input words, owns the glyph table, classifies characters and
// precomputes scaled sizes and pen steps for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module gle_front #(
  parameter int GLYPH_CODES = 256
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_opcode,
  input  wire logic [15:0]         in_code,
  input  wire logic [11:0]         in_tex_x,
  input  wire logic [11:0]         in_tex_y,
  input  wire logic [11:0]         in_tex_w,
  input  wire logic [11:0]         in_tex_h,
  input  wire logic signed [11:0]  in_x_offset,
  input  wire logic signed [11:0]  in_y_offset,
  input  wire logic signed [11:0]  in_x_advance,
  input  wire logic [3:0]          in_page,
  input  wire logic signed [19:0]  in_origin_x,
  input  wire logic signed [19:0]  in_origin_y,
  input  wire gle_pkg::cfg_t       cfg,
  output gle_pkg::job_t            q_wdata,
  output logic                     q_push,
  input  wire logic                q_full,
  output logic                     clr_busy
);

  import gle_pkg::*;

  localparam int AW    = $clog2(GLYPH_CODES);
  localparam int RAM_W = $bits(glyph_t) + 1;

  logic             accept;
  logic             in_range;
  glyph_t           wr_entry;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [RAM_W-1:0] ram_wdata;
  logic [RAM_W-1:0] ram_rdata;

  logic             clr_r,     clr_nxt;
  logic [AW-1:0]    clr_cnt_r, clr_cnt_nxt;
  glyph_t           space_r;
  logic             space_v_r;

  logic             f1_v_r;
  logic [1:0]       f1_op_r;
  logic             f1_nl_r;
  logic             f1_rng_r;
  logic signed [19:0] f1_org_x_r;
  logic signed [19:0] f1_org_y_r;
  glyph_t           f1_space_r;
  logic             f1_space_v_r;
  logic             f1_go;

  logic             hit;
  glyph_t           g;
  logic signed [24:0] adv_p;
  logic signed [24:0] adv_s;
  logic [23:0]      nl_p;
  logic [24:0]      nl_s;
  logic [23:0]      w_p;
  logic [24:0]      w_s;
  logic [23:0]      h_p;
  logic [24:0]      h_s;

  // handshake
  assign f1_go    = !f1_v_r || !q_full;
  assign in_ready = !clr_r && f1_go;
  assign accept   = in_valid && in_ready;
  assign in_range = 32'(in_code) < 32'(GLYPH_CODES);
  assign clr_busy = clr_r;

  // entry to store
  always_comb begin
    wr_entry.page  = in_page;
    wr_entry.tex_x = in_tex_x;
    wr_entry.tex_y = in_tex_y;
    wr_entry.tex_w = in_tex_w;
    wr_entry.tex_h = in_tex_h;
    wr_entry.x_off = in_x_offset;
    wr_entry.y_off = in_y_offset;
    wr_entry.x_adv = in_x_advance;
  end

  // table write port: clearing pass after reset, then glyph writes
  assign ram_we    = clr_r || (accept && (in_opcode == OP_WRITE) && in_range);
  assign ram_waddr = clr_r ? clr_cnt_r : in_code[AW-1:0];
  assign ram_wdata = clr_r ? '0 : {1'b1, wr_entry};

  gle_ram #(
    .WIDTH (RAM_W),
    .DEPTH (GLYPH_CODES)
  ) u_tab (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (accept),
    .raddr   (in_code[AW-1:0]),
    .rdata_r (ram_rdata)
  );

  // clearing pass sequencing
  always_comb begin
    clr_nxt     = clr_r;
    clr_cnt_nxt = clr_cnt_r;
    if (clr_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(GLYPH_CODES - 1)) begin
        clr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else begin
      clr_r     <= clr_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // shadow copy of the space glyph for fallback
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_v_r <= 1'b0;
    end else if (accept && (in_opcode == OP_WRITE) && in_range && (in_code == CODE_SPACE)) begin
      space_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_opcode == OP_WRITE) && in_range && (in_code == CODE_SPACE)) begin
      space_r <= wr_entry;
    end
  end

  // lookup stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (f1_go) begin
      f1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_op_r      <= in_opcode;
      f1_nl_r      <= (in_code == CODE_NEWLINE);
      f1_rng_r     <= in_range;
      f1_org_x_r   <= in_origin_x;
      f1_org_y_r   <= in_origin_y;
      f1_space_r   <= space_r;
      f1_space_v_r <= space_v_r;
    end
  end

  // pick glyph, own entry first then space
  assign hit = f1_rng_r && ram_rdata[RAM_W-1];
  assign g   = hit ? ram_rdata[RAM_W-2:0] : f1_space_r;

  // scaled advance, line step and sizes, round half up
  assign adv_p = 25'(g.x_adv) * 25'(signed'({1'b0, cfg.scale_q8}));
  assign adv_s = adv_p + 25'sd8;
  assign nl_p  = 24'(cfg.line_height) * 24'(cfg.scale_q8);
  assign nl_s  = {1'b0, nl_p} + 25'd8;
  assign w_p   = 24'(g.tex_w) * 24'(cfg.scale_q8);
  assign w_s   = {1'b0, w_p} + 25'd8;
  assign h_p   = 24'(g.tex_h) * 24'(cfg.scale_q8);
  assign h_s   = {1'b0, h_p} + 25'd8;

  // build the job
  always_comb begin
    q_wdata.kind  = KIND_MISS;
    q_wdata.org_x = f1_org_x_r;
    q_wdata.org_y = f1_org_y_r;
    q_wdata.page  = g.page;
    q_wdata.src_x = g.tex_x;
    q_wdata.src_y = g.tex_y;
    q_wdata.src_w = g.tex_w;
    q_wdata.src_h = g.tex_h;
    q_wdata.x_off = g.x_off;
    q_wdata.y_off = g.y_off;
    q_wdata.step  = {10'b0, cfg.missing_advance, 4'b0};
    q_wdata.dst_w = sat_size(w_s[24:4]);
    q_wdata.dst_h = sat_size(h_s[24:4]);
    if (f1_op_r == OP_BEGIN) begin
      q_wdata.kind = KIND_BEGIN;
    end else if (f1_nl_r) begin
      q_wdata.kind = KIND_NEWLINE;
      q_wdata.step = {1'b0, nl_s[24:4]};
    end else if (hit || f1_space_v_r) begin
      q_wdata.kind = KIND_GLYPH;
      q_wdata.step = 22'($signed(adv_s[24:4]));
    end
  end

  assign q_push = f1_v_r && !q_full && ((f1_op_r == OP_BEGIN) || (f1_op_r == OP_CHAR));

endmodule

`default_nettype wire

// File: src/gle_queue.sv
// ----------------------------------------------------------------------------
// gle_queue
// Four entry job queue decoupling the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module gle_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire gle_pkg::job_t wdata,
  input  wire logic          pop,
  output gle_pkg::job_t      rdata,
  output logic               full,
  output logic               empty
);

  import gle_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   count_r, count_nxt;

  assign full  = (count_r == (PW+1)'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/gle_back.sv
// ----------------------------------------------------------------------------
// gle_back
// Owns the pen, applies each job to it and rotates placed glyphs about the
// origin through a three stage multiply pipeline into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gle_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire gle_pkg::job_t       head,
  input  wire logic                q_empty,
  output logic                     q_pop,
  input  wire gle_pkg::cfg_t       cfg,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [3:0]               out_page,
  output logic [11:0]              out_src_x,
  output logic [11:0]              out_src_y,
  output logic [11:0]              out_src_w,
  output logic [11:0]              out_src_h,
  output logic signed [19:0]       out_dest_x,
  output logic signed [19:0]       out_dest_y,
  output logic [19:0]              out_dest_w,
  output logic [19:0]              out_dest_h
);

  import gle_pkg::*;

  logic en;

  logic signed [19:0] pen_x_r, pen_x_nxt;
  logic signed [19:0] pen_y_r, pen_y_nxt;
  logic signed [19:0] start_x_r, start_x_nxt;
  logic signed [19:0] start_y_r, start_y_nxt;
  logic signed [21:0] dx;
  logic signed [21:0] dy;

  logic               b1_v_r;
  logic signed [21:0] b1_dx_r, b1_dy_r;
  logic signed [19:0] b1_sx_r, b1_sy_r;
  job_t               b1_job_r;

  logic               b2_v_r;
  logic signed [37:0] b2_xc_r, b2_ys_r, b2_xs_r, b2_yc_r;
  logic signed [19:0] b2_sx_r, b2_sy_r;
  job_t               b2_job_r;

  logic signed [39:0] rx_sum, ry_sum;
  logic               out_valid_r;

  // whole back end moves when the output register can take a word
  assign en    = !out_valid_r || out_ready;
  assign q_pop = en && !q_empty;

  // pen update
  always_comb begin
    pen_x_nxt   = pen_x_r;
    pen_y_nxt   = pen_y_r;
    start_x_nxt = start_x_r;
    start_y_nxt = start_y_r;
    case (head.kind)
      KIND_BEGIN: begin
        start_x_nxt = head.org_x;
        start_y_nxt = head.org_y;
        pen_x_nxt   = head.org_x;
        pen_y_nxt   = head.org_y;
      end
      KIND_NEWLINE: begin
        pen_y_nxt = sat_pos(27'(pen_y_r) + 27'(head.step));
        pen_x_nxt = start_x_r;
      end
      KIND_MISS, KIND_GLYPH: begin
        pen_x_nxt = sat_pos(27'(pen_x_r) + 27'(head.step));
      end
      default: begin
        pen_x_nxt = pen_x_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r   <= '0;
      pen_y_r   <= '0;
      start_x_r <= '0;
      start_y_r <= '0;
    end else if (q_pop) begin
      pen_x_r   <= pen_x_nxt;
      pen_y_r   <= pen_y_nxt;
      start_x_r <= start_x_nxt;
      start_y_r <= start_y_nxt;
    end
  end

  // offset from origin before rotation
  assign dx = 22'(pen_x_r) + 22'($signed({head.x_off, 4'b0})) - 22'(start_x_r);
  assign dy = 22'(pen_y_r) + 22'($signed({head.y_off, 4'b0})) - 22'(start_y_r);

  // stage one: capture placement
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
    end else if (en) begin
      b1_v_r <= q_pop && (head.kind == KIND_GLYPH);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_dx_r  <= dx;
      b1_dy_r  <= dy;
      b1_sx_r  <= start_x_r;
      b1_sy_r  <= start_y_r;
      b1_job_r <= head;
    end
  end

  // stage two: rotation products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_v_r <= 1'b0;
    end else if (en) begin
      b2_v_r <= b1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b2_xc_r  <= 38'(b1_dx_r) * 38'(cfg.rot_cos);
      b2_ys_r  <= 38'(b1_dy_r) * 38'(cfg.rot_sin);
      b2_xs_r  <= 38'(b1_dx_r) * 38'(cfg.rot_sin);
      b2_yc_r  <= 38'(b1_dy_r) * 38'(cfg.rot_cos);
      b2_sx_r  <= b1_sx_r;
      b2_sy_r  <= b1_sy_r;
      b2_job_r <= b1_job_r;
    end
  end

  // sums, round half up, back to Q16.4
  assign rx_sum = 40'(b2_xc_r) - 40'(b2_ys_r) + 40'sd8192;
  assign ry_sum = 40'(b2_xs_r) + 40'(b2_yc_r) + 40'sd8192;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= b2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_page   <= b2_job_r.page;
      out_src_x  <= b2_job_r.src_x;
      out_src_y  <= b2_job_r.src_y;
      out_src_w  <= b2_job_r.src_w;
      out_src_h  <= b2_job_r.src_h;
      out_dest_x <= sat_pos(27'(b2_sx_r) + 27'($signed(rx_sum[39:14])));
      out_dest_y <= sat_pos(27'(b2_sy_r) + 27'($signed(ry_sum[39:14])));
      out_dest_w <= b2_job_r.dst_w;
      out_dest_h <= b2_job_r.dst_h;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: src/glyph_layout_engine_unit.sv
// ----------------------------------------------------------------------------
// glyph_layout_engine_unit
// Bitmap font text placement: glyph table, pen tracking and rotated output.
// ----------------------------------------------------------------------------
// Takes one input word per clock when the output side keeps up: glyph table
// writes, begin words and characters all issue at one per cycle, limited by
// the single table read per character. A placed glyph reaches the output
// through the table read at the edge that accepts it, then classify into
// the queue, pen, rotate multiply, round and saturate, later if the four
// entry job queue holds work. After reset a clearing pass wipes the table
// valid marks; no word is accepted during it, register writes are.
`default_nettype none

module glyph_layout_engine_unit #(
  parameter int GLYPH_CODES = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [15:0]        in_code,
  input  wire logic [11:0]        in_tex_x,
  input  wire logic [11:0]        in_tex_y,
  input  wire logic [11:0]        in_tex_w,
  input  wire logic [11:0]        in_tex_h,
  input  wire logic signed [11:0] in_x_offset,
  input  wire logic signed [11:0] in_y_offset,
  input  wire logic signed [11:0] in_x_advance,
  input  wire logic [3:0]         in_page,
  input  wire logic signed [19:0] in_origin_x,
  input  wire logic signed [19:0] in_origin_y,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [3:0]              out_page,
  output logic [11:0]             out_src_x,
  output logic [11:0]             out_src_y,
  output logic [11:0]             out_src_w,
  output logic [11:0]             out_src_h,
  output logic signed [19:0]      out_dest_x,
  output logic signed [19:0]      out_dest_y,
  output logic [19:0]             out_dest_w,
  output logic [19:0]             out_dest_h,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  import gle_pkg::*;

  localparam logic [2:0] REG_LINE_HEIGHT = 3'd0;
  localparam logic [2:0] REG_SCALE       = 3'd1;
  localparam logic [2:0] REG_ROT_COS     = 3'd2;
  localparam logic [2:0] REG_ROT_SIN     = 3'd3;
  localparam logic [2:0] REG_MISS_ADV    = 3'd4;

  cfg_t cfg_r;
  logic cfg_wr;
  job_t q_wdata;
  job_t q_rdata;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  logic clr_busy;

  // register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_height     <= 12'd16;
      cfg_r.scale_q8        <= 12'd256;
      cfg_r.rot_cos         <= 16'sd16384;
      cfg_r.rot_sin         <= 16'sd0;
      cfg_r.missing_advance <= 8'd10;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_LINE_HEIGHT: cfg_r.line_height     <= pwdata[11:0];
        REG_SCALE:       cfg_r.scale_q8        <= pwdata[11:0];
        REG_ROT_COS:     cfg_r.rot_cos         <= pwdata[15:0];
        REG_ROT_SIN:     cfg_r.rot_sin         <= pwdata[15:0];
        REG_MISS_ADV:    cfg_r.missing_advance <= pwdata[7:0];
        default:         cfg_r.missing_advance <= cfg_r.missing_advance;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[4:2])
      REG_LINE_HEIGHT: prdata = {20'b0, cfg_r.line_height};
      REG_SCALE:       prdata = {20'b0, cfg_r.scale_q8};
      REG_ROT_COS:     prdata = 32'(cfg_r.rot_cos);
      REG_ROT_SIN:     prdata = 32'(cfg_r.rot_sin);
      REG_MISS_ADV:    prdata = {24'b0, cfg_r.missing_advance};
      default:         prdata = '0;
    endcase
  end

  // front end
  gle_front #(
    .GLYPH_CODES (GLYPH_CODES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_code      (in_code),
    .in_tex_x     (in_tex_x),
    .in_tex_y     (in_tex_y),
    .in_tex_w     (in_tex_w),
    .in_tex_h     (in_tex_h),
    .in_x_offset  (in_x_offset),
    .in_y_offset  (in_y_offset),
    .in_x_advance (in_x_advance),
    .in_page      (in_page),
    .in_origin_x  (in_origin_x),
    .in_origin_y  (in_origin_y),
    .cfg          (cfg_r),
    .q_wdata      (q_wdata),
    .q_push       (q_push),
    .q_full       (q_full),
    .clr_busy     (clr_busy)
  );

  // job queue
  gle_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // back end
  gle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_rdata),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .cfg        (cfg_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_page   (out_page),
    .out_src_x  (out_src_x),
    .out_src_y  (out_src_y),
    .out_src_w  (out_src_w),
    .out_src_h  (out_src_h),
    .out_dest_x (out_dest_x),
    .out_dest_y (out_dest_y),
    .out_dest_w (out_dest_w),
    .out_dest_h (out_dest_h)
  );

  // queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("job queue overflow");

  // queue never underflows
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("job queue underflow");

  // no word taken while the table is being cleared
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_ready) else $error("word accepted during clearing pass");

endmodule

`default_nettype wire

// File: sim/tb_gle_defs_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gle_defs_pkg
// Register map and word layout shared by the glyph layout testbench files.
// ----------------------------------------------------------------------------
package tb_gle_defs_pkg;

  // register byte addresses
  localparam logic [4:0] REG_LINE_HEIGHT = 5'd0;
  localparam logic [4:0] REG_SCALE       = 5'd4;
  localparam logic [4:0] REG_ROT_COS     = 5'd8;
  localparam logic [4:0] REG_ROT_SIN     = 5'd12;
  localparam logic [4:0] REG_MISS_ADV    = 5'd16;

  localparam int TABLE_CODES = 256;

  // one input word
  typedef struct packed {
    logic [1:0]         opcode;
    logic [15:0]        code;
    logic [11:0]        tex_x;
    logic [11:0]        tex_y;
    logic [11:0]        tex_w;
    logic [11:0]        tex_h;
    logic signed [11:0] x_offset;
    logic signed [11:0] y_offset;
    logic signed [11:0] x_advance;
    logic [3:0]         page;
    logic signed [19:0] origin_x;
    logic signed [19:0] origin_y;
  } text_word_t;

endpackage

// File: sim/glyph_placement_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glyph_placement_checker
// Watches the word channels and the register port, predicts each glyph
// placement and compares it field by field with what the engine emits.
// ----------------------------------------------------------------------------
module glyph_placement_checker
  import gle_pkg::*;
  import tb_gle_defs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [15:0]        in_code,
  input  logic [11:0]        in_tex_x,
  input  logic [11:0]        in_tex_y,
  input  logic [11:0]        in_tex_w,
  input  logic [11:0]        in_tex_h,
  input  logic signed [11:0] in_x_offset,
  input  logic signed [11:0] in_y_offset,
  input  logic signed [11:0] in_x_advance,
  input  logic [3:0]         in_page,
  input  logic signed [19:0] in_origin_x,
  input  logic signed [19:0] in_origin_y,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [3:0]         out_page,
  input  logic [11:0]        out_src_x,
  input  logic [11:0]        out_src_y,
  input  logic [11:0]        out_src_w,
  input  logic [11:0]        out_src_h,
  input  logic signed [19:0] out_dest_x,
  input  logic signed [19:0] out_dest_y,
  input  logic [19:0]        out_dest_w,
  input  logic [19:0]        out_dest_h,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending_count
);

  typedef struct packed {
    logic [3:0]  page;
    logic [11:0] src_x;
    logic [11:0] src_y;
    logic [11:0] src_w;
    logic [11:0] src_h;
    logic [19:0] dest_x;
    logic [19:0] dest_y;
    logic [19:0] dest_w;
    logic [19:0] dest_h;
  } placement_t;

  glyph_t     font_tab [TABLE_CODES];
  bit         font_vld [TABLE_CODES];
  longint     pen_x, pen_y, org_x, org_y;
  longint     line_h, scale, cos_q14, sin_q14, miss_adv;
  placement_t placements_due [$];

  assign pending_count = placements_due.size();

  function automatic longint clamp_pos(longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  function automatic longint clamp_size(longint v);
    if (v > 1048575) return 1048575;
    if (v < 0) return 0;
    return v;
  endfunction

  // round half up from q.8 pixel products to q.4
  function automatic longint round_q4(longint v);
    return (v + 8) >>> 4;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // layout behaviour for one accepted word
  task automatic place_word(text_word_t w);
    glyph_t     g;
    int         idx;
    longint     dx, dy, rx, ry;
    placement_t p;
    case (w.opcode)
      OP_WRITE: begin
        if (w.code < TABLE_CODES) begin
          g.page  = w.page;
          g.tex_x = w.tex_x;
          g.tex_y = w.tex_y;
          g.tex_w = w.tex_w;
          g.tex_h = w.tex_h;
          g.x_off = w.x_offset;
          g.y_off = w.y_offset;
          g.x_adv = w.x_advance;
          font_tab[w.code] = g;
          font_vld[w.code] = 1'b1;
        end
      end
      OP_BEGIN: begin
        org_x = longint'(w.origin_x);
        org_y = longint'(w.origin_y);
        pen_x = org_x;
        pen_y = org_y;
      end
      OP_CHAR: begin
        if (w.code == CODE_NEWLINE) begin
          pen_y = clamp_pos(pen_y + round_q4(line_h * scale));
          pen_x = org_x;
        end else begin
          if (w.code < TABLE_CODES && font_vld[w.code]) idx = w.code;
          else if (font_vld[CODE_SPACE]) idx = CODE_SPACE;
          else idx = -1;
          if (idx < 0) begin
            // no glyph and no space to fall back on
            pen_x = clamp_pos(pen_x + miss_adv * 16);
          end else begin
            g  = font_tab[idx];
            dx = pen_x + longint'(g.x_off) * 16 - org_x;
            dy = pen_y + longint'(g.y_off) * 16 - org_y;
            rx = (dx * cos_q14 - dy * sin_q14 + 8192) >>> 14;
            ry = (dx * sin_q14 + dy * cos_q14 + 8192) >>> 14;
            p.page   = g.page;
            p.src_x  = g.tex_x;
            p.src_y  = g.tex_y;
            p.src_w  = g.tex_w;
            p.src_h  = g.tex_h;
            p.dest_x = 20'(clamp_pos(org_x + rx));
            p.dest_y = 20'(clamp_pos(org_y + ry));
            p.dest_w = 20'(clamp_size(round_q4(longint'(g.tex_w) * scale)));
            p.dest_h = 20'(clamp_size(round_q4(longint'(g.tex_h) * scale)));
            placements_due = {placements_due, p};
            pen_x = clamp_pos(pen_x + round_q4(longint'(g.x_adv) * scale));
          end
        end
      end
      default: ;
    endcase
  endtask

  // watch both channels and the register port
  always @(posedge clk) begin
    text_word_t w;
    placement_t e;
    if (!rst_n) begin
      foreach (font_vld[i]) font_vld[i] = 1'b0;
      pen_x = 0; pen_y = 0; org_x = 0; org_y = 0;
      line_h = 16; scale = 256; cos_q14 = 16384; sin_q14 = 0; miss_adv = 10;
      placements_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          REG_LINE_HEIGHT: line_h   = longint'(pwdata[11:0]);
          REG_SCALE:       scale    = longint'(pwdata[11:0]);
          REG_ROT_COS:     cos_q14  = longint'($signed(pwdata[15:0]));
          REG_ROT_SIN:     sin_q14  = longint'($signed(pwdata[15:0]));
          REG_MISS_ADV:    miss_adv = longint'(pwdata[7:0]);
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (placements_due.size() == 0) begin
          report_mismatch("unexpected word, dest_x", longint'(out_dest_x), 0);
        end else begin
          e = placements_due.pop_front();
          if (out_page != e.page) report_mismatch("page", out_page, e.page);
          if (out_src_x != e.src_x) report_mismatch("src_x", out_src_x, e.src_x);
          if (out_src_y != e.src_y) report_mismatch("src_y", out_src_y, e.src_y);
          if (out_src_w != e.src_w) report_mismatch("src_w", out_src_w, e.src_w);
          if (out_src_h != e.src_h) report_mismatch("src_h", out_src_h, e.src_h);
          if (out_dest_x != e.dest_x)
            report_mismatch("dest_x", longint'(out_dest_x), longint'($signed(e.dest_x)));
          if (out_dest_y != e.dest_y)
            report_mismatch("dest_y", longint'(out_dest_y), longint'($signed(e.dest_y)));
          if (out_dest_w != e.dest_w) report_mismatch("dest_w", out_dest_w, e.dest_w);
          if (out_dest_h != e.dest_h) report_mismatch("dest_h", out_dest_h, e.dest_h);
        end
      end
      if (in_valid && in_ready) begin
        w = '{in_opcode, in_code, in_tex_x, in_tex_y, in_tex_w, in_tex_h,
              in_x_offset, in_y_offset, in_x_advance, in_page, in_origin_x, in_origin_y};
        place_word(w);
      end
    end
  end

  initial fail_count = 0;

endmodule

// File: sim/tb_glyph_layout_engine_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_glyph_layout_engine_unit
// Drives glyph writes, begin words and text through the layout engine under
// random idling and back pressure across several register settings; the
// placement checker predicts and compares every emitted glyph.
// ----------------------------------------------------------------------------
module tb_glyph_layout_engine_unit;
  import gle_pkg::*;
  import tb_gle_defs_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_opcode;
  logic [15:0]        in_code;
  logic [11:0]        in_tex_x, in_tex_y, in_tex_w, in_tex_h;
  logic signed [11:0] in_x_offset, in_y_offset, in_x_advance;
  logic [3:0]         in_page;
  logic signed [19:0] in_origin_x, in_origin_y;
  logic               out_valid;
  logic               out_ready;
  logic [3:0]         out_page;
  logic [11:0]        out_src_x, out_src_y, out_src_w, out_src_h;
  logic signed [19:0] out_dest_x, out_dest_y;
  logic [19:0]        out_dest_w, out_dest_h;
  logic               psel, penable, pwrite, pready;
  logic [4:0]         paddr;
  logic [31:0]        pwdata, prdata;
  int                 fail_count;
  int                 pending_count;
  int                 tx_idle_pct, rx_idle_pct;
  int                 rx_hold_cycles;
  int                 cycle_count;

  glyph_layout_engine_unit DUT (.*);
  glyph_placement_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // result side ready, with a long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        out_ready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // offer one word and hold it until taken
  task automatic send_word(text_word_t w);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= w.opcode;
    in_code      <= w.code;
    in_tex_x     <= w.tex_x;
    in_tex_y     <= w.tex_y;
    in_tex_w     <= w.tex_w;
    in_tex_h     <= w.tex_h;
    in_x_offset  <= w.x_offset;
    in_y_offset  <= w.y_offset;
    in_x_advance <= w.x_advance;
    in_page      <= w.page;
    in_origin_x  <= w.origin_x;
    in_origin_y  <= w.origin_y;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic reg_write(logic [4:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // wait until every placement is out and the pipeline has settled
  task automatic drain_engine();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_layout(int lh, int sc, int cs, int sn, int ma);
    reg_write(REG_LINE_HEIGHT, 32'(lh));
    reg_write(REG_SCALE, 32'(sc));
    reg_write(REG_ROT_COS, 32'(cs));
    reg_write(REG_ROT_SIN, 32'(sn));
    reg_write(REG_MISS_ADV, 32'(ma));
  endtask

  function automatic text_word_t make_word(logic [1:0] op, logic [15:0] code);
    text_word_t w;
    w.opcode    = op;
    w.code      = code;
    w.tex_x     = 12'($urandom);
    w.tex_y     = 12'($urandom);
    w.tex_w     = 12'($urandom);
    w.tex_h     = 12'($urandom);
    w.x_offset  = 12'($urandom);
    w.y_offset  = 12'($urandom);
    w.x_advance = 12'($urandom);
    w.page      = 4'($urandom);
    w.origin_x  = 20'($urandom);
    w.origin_y  = 20'($urandom);
    return w;
  endfunction

  // mostly characters on a well populated table, some noise
  function automatic text_word_t random_word();
    text_word_t w;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      w = make_word(OP_WRITE, ($urandom_range(19) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(255)));
    end else if (pick < 20) begin
      w = make_word(OP_BEGIN, 16'($urandom));
      if ($urandom_range(3) != 0) begin
        w.origin_x = 20'($signed($urandom_range(8000)) - 4000);
        w.origin_y = 20'($signed($urandom_range(8000)) - 4000);
      end
    end else if (pick < 96) begin
      pick = $urandom_range(9);
      if (pick == 0) w = make_word(OP_CHAR, CODE_NEWLINE);
      else if (pick < 8) w = make_word(OP_CHAR, 16'($urandom_range(255)));
      else w = make_word(OP_CHAR, 16'($urandom));
    end else begin
      w = make_word(2'd3, 16'($urandom));
    end
    if (w.opcode == OP_WRITE && $urandom_range(3) != 0) begin
      // keep most glyphs modest so the pen stays on screen
      w.tex_w     = 12'($urandom_range(64));
      w.tex_h     = 12'($urandom_range(64));
      w.x_offset  = 12'($signed($urandom_range(40)) - 20);
      w.y_offset  = 12'($signed($urandom_range(40)) - 20);
      w.x_advance = 12'($urandom_range(48));
    end
    return w;
  endfunction

  // directed words covering the special cases
  task automatic run_directed();
    text_word_t w;
    send_word(make_word(OP_CHAR, 16'd65));         // no glyph, no space
    send_word(make_word(OP_CHAR, CODE_NEWLINE));
    send_word(make_word(2'd3, 16'd65));            // unknown opcode
    send_word(make_word(OP_WRITE, 16'd300));       // write beyond table
    send_word(make_word(OP_CHAR, 16'd300));
    w = make_word(OP_WRITE, 16'd65);
    w.tex_x = '1; w.tex_y = '1; w.tex_w = '1; w.tex_h = '1; w.page = '1;
    w.x_offset = 12'sh7FF; w.y_offset = 12'sh7FF; w.x_advance = 12'sh7FF;
    send_word(w);
    send_word(make_word(OP_WRITE, CODE_NEWLINE));  // glyph stored on newline
    send_word(make_word(OP_CHAR, CODE_NEWLINE));
    send_word(make_word(OP_CHAR, 16'd65));
    send_word(make_word(OP_WRITE, CODE_SPACE));
    send_word(make_word(OP_CHAR, 16'd66));         // falls back to space
    send_word(make_word(OP_CHAR, 16'hFFFF));       // code beyond table
    w = make_word(OP_BEGIN, 16'd0);
    w.origin_x = 20'sh7FFFF; w.origin_y = 20'sh7FFFF;
    send_word(w);
    send_word(make_word(OP_CHAR, 16'd65));
    w = make_word(OP_WRITE, 16'd0);
    w.tex_x = '0; w.tex_y = '0; w.tex_w = '0; w.tex_h = '0; w.page = '0;
    w.x_offset = 12'sh800; w.y_offset = 12'sh800; w.x_advance = 12'sh800;
    send_word(w);
    w = make_word(OP_BEGIN, 16'd0);
    w.origin_x = 20'sh80000; w.origin_y = 20'sh80000;
    send_word(w);
    send_word(make_word(OP_CHAR, 16'd0));
    send_word(make_word(OP_WRITE, 16'd255));
    send_word(make_word(OP_CHAR, 16'd255));
    send_word(make_word(OP_CHAR, CODE_NEWLINE));
    send_word(make_word(OP_CHAR, CODE_SPACE));
  endtask

  // stimulus
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = '0;
    in_code        = '0;
    in_tex_x       = '0;
    in_tex_y       = '0;
    in_tex_w       = '0;
    in_tex_h       = '0;
    in_x_offset    = '0;
    in_y_offset    = '0;
    in_x_advance   = '0;
    in_page        = '0;
    in_origin_x    = '0;
    in_origin_y    = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    tx_idle_pct    = 10;
    rx_idle_pct    = 68;
    rx_hold_cycles = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    drain_engine();

    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0: set_layout(4095, 4095, -16384, 16384, 255);
        1: set_layout(0, 0, 0, -16384, 0);
        2: set_layout(16, 256, 16384, 0, 10);
        default: set_layout($urandom_range(40), $urandom_range(1, 1024),
                            $signed($urandom_range(32768)) - 16384,
                            $signed($urandom_range(32768)) - 16384,
                            $urandom_range(255));
      endcase
      case (seg / 2)
        0: begin tx_idle_pct = 10; rx_idle_pct = 68; end
        1: begin tx_idle_pct = 68; rx_idle_pct = 10; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int n = 0; n < 240; n++) begin
        if (seg == 4 && n == 60) begin
          @(negedge clk);
          rx_hold_cycles = 500;
        end
        send_word(random_word());
      end
      drain_engine();
    end

    if (fail_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: glyph_layout_engine_unit.f
src/gle_pkg.sv
src/gle_ram.sv
src/gle_front.sv
src/gle_queue.sv
src/gle_back.sv
src/glyph_layout_engine_unit.sv
sim/tb_gle_defs_pkg.sv
sim/glyph_placement_checker.sv
sim/tb_glyph_layout_engine_unit.sv
